[rtl/lzd_pkg.sv]
// ----------------------------------------------------------------------------
// lzd_pkg
// Types and constants shared by the LZ77 token decoder and its channels.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int DIST_W = 13;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  copy_length;
    logic [BYTE_W-1:0] literal;
  } lzd_token_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              last;
    logic              stream_end;
    logic              bad_distance;
  } lzd_result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EMIT,
    S_LIT
  } lzd_state_t;

endpackage

[rtl/lzd_chan_if.sv]
// ----------------------------------------------------------------------------
// lzd_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface lzd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/lz77_token_decoder.sv]
// ----------------------------------------------------------------------------
// lz77_token_decoder
// LZ77 token decoder with a ring-buffer history window.
//
//   channel | dir | payload       | transfer
//   tok     | in  | lzd_token_t   | tok.valid && tok.ready
//   res     | out | lzd_result_t  | res.valid && res.ready
//
// A token is taken in S_IDLE and checked in S_CHECK; each copied byte is then
// read from the history (S_READ) and written and emitted (S_EMIT), and the
// literal, if any, is written and emitted last (S_LIT).
// Reset (rst, synchronous) clears the fill count and ring index; the history
// memory is not cleared. A stalled result holds its register and freezes the
// sequencer; the next token is taken while the last result still waits.
// ----------------------------------------------------------------------------
module lz77_token_decoder
  import lzd_pkg::*;
#(
  parameter int WINDOW   = 4096,
  parameter int MAX_COPY = 63
) (
  input  logic      clk,
  input  logic      rst,
  lzd_chan_if.sink   tok,
  lzd_chan_if.source res
);

  localparam int WI_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int HELD_W = $clog2(WINDOW + 1);
  localparam int CMP_W  = (HELD_W > DIST_W) ? HELD_W : DIST_W;
  localparam int SUB_W  = CMP_W + 1;

  lzd_state_t state, state_next;
  lzd_token_t tok_q, tok_q_next;
  logic                 bad, bad_next;
  logic                 emitted, emitted_next;
  logic [WI_W-1:0]      rd_ptr, rd_ptr_next;
  logic [LEN_W-1:0]     cnt, cnt_next;
  logic [WI_W-1:0]      wi, wi_next;
  logic [HELD_W-1:0]    held, held_next;
  logic                 out_valid, out_valid_next;
  lzd_result_t          out_q, out_q_next;

  logic [BYTE_W-1:0]    history [WINDOW];
  logic [BYTE_W-1:0]    rdata;
  logic                 mem_we;
  logic [BYTE_W-1:0]    mem_wdata;

  logic                 slot_free;
  logic                 has_copy;
  logic                 too_far;
  logic [LEN_W-1:0]     len_c;
  logic [SUB_W-1:0]     wi_x, dist_x, src_x;
  logic [WI_W-1:0]      wi_inc, rd_inc;
  logic [HELD_W-1:0]    held_inc;

  assign slot_free = !out_valid || res.ready;
  assign tok.ready = (state == S_IDLE) && !rst;
  assign res.valid = out_valid;
  assign res.payload = out_q;

  assign len_c    = (tok_q.copy_length > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY)
                                                           : tok_q.copy_length;
  assign has_copy = (tok_q.distance != '0) && (tok_q.copy_length != '0);
  assign too_far  = CMP_W'(tok_q.distance) > CMP_W'(held);
  assign wi_x     = SUB_W'(wi);
  assign dist_x   = SUB_W'(tok_q.distance);
  assign src_x    = (wi_x >= dist_x) ? (wi_x - dist_x)
                                     : (wi_x + SUB_W'(WINDOW) - dist_x);
  assign wi_inc   = (wi == WI_W'(WINDOW - 1)) ? '0 : wi + 1'b1;
  assign rd_inc   = (rd_ptr == WI_W'(WINDOW - 1)) ? '0 : rd_ptr + 1'b1;
  assign held_inc = (held == HELD_W'(WINDOW)) ? held : held + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wi        <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wi        <= wi_next;
      held      <= held_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_q   <= tok_q_next;
    bad     <= bad_next;
    emitted <= emitted_next;
    rd_ptr  <= rd_ptr_next;
    cnt     <= cnt_next;
    out_q   <= out_q_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[wi] <= mem_wdata;
    end
    if (state == S_READ) begin
      rdata <= history[rd_ptr];
    end
  end

  always_comb begin
    state_next     = state;
    tok_q_next     = tok_q;
    bad_next       = bad;
    emitted_next   = emitted;
    rd_ptr_next    = rd_ptr;
    cnt_next       = cnt;
    wi_next        = wi;
    held_next      = held;
    out_valid_next = out_valid && !res.ready;
    out_q_next     = out_q;
    mem_we         = 1'b0;
    mem_wdata      = rdata;

    case (state)
      S_IDLE: begin
        if (tok.valid) begin
          tok_q_next = tok.payload;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        emitted_next = 1'b0;
        bad_next     = has_copy && too_far;
        rd_ptr_next  = src_x[WI_W-1:0];
        cnt_next     = len_c;
        if (has_copy && !too_far) begin
          state_next = S_READ;
        end else begin
          state_next = S_LIT;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_next          = 1'b1;
          out_q_next.out_byte     = rdata;
          out_q_next.has_byte     = 1'b1;
          out_q_next.last         = (cnt == LEN_W'(1)) && (tok_q.literal == '0);
          out_q_next.stream_end   = (cnt == LEN_W'(1)) && (tok_q.literal == '0);
          out_q_next.bad_distance = 1'b0;
          mem_we       = 1'b1;
          wi_next      = wi_inc;
          held_next    = held_inc;
          rd_ptr_next  = rd_inc;
          cnt_next     = cnt - 1'b1;
          emitted_next = 1'b1;
          state_next   = (cnt == LEN_W'(1)) ? S_LIT : S_READ;
        end
      end
      S_LIT: begin
        if (tok_q.literal != '0) begin
          if (slot_free) begin
            out_valid_next          = 1'b1;
            out_q_next.out_byte     = tok_q.literal;
            out_q_next.has_byte     = 1'b1;
            out_q_next.last         = 1'b1;
            out_q_next.stream_end   = 1'b0;
            out_q_next.bad_distance = bad;
            mem_we     = 1'b1;
            mem_wdata  = tok_q.literal;
            wi_next    = wi_inc;
            held_next  = held_inc;
            state_next = S_IDLE;
          end
        end else if (emitted) begin
          held_next  = '0;
          state_next = S_IDLE;
        end else if (slot_free) begin
          out_valid_next          = 1'b1;
          out_q_next.out_byte     = '0;
          out_q_next.has_byte     = 1'b0;
          out_q_next.last         = 1'b1;
          out_q_next.stream_end   = 1'b1;
          out_q_next.bad_distance = bad;
          held_next  = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    HELD_W'(WINDOW) >= held)
    else $error("fill count above window size");

  a_wi_bound: assert property (@(posedge clk) disable iff (rst)
    WI_W'(WINDOW - 1) >= wi)
    else $error("ring index out of range");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.payload.stream_end |-> res.payload.last)
    else $error("stream end flagged on a non-final result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.payload.has_byte |->
      res.payload.stream_end && (res.payload.out_byte == '0))
    else $error("byte-less result that does not end the stream");

  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (cnt != '0) && !bad)
    else $error("copy step with no bytes left or a skipped copy");
`endif

endmodule
